[sv/hkrt_pkg.sv]
// Package for the Hall-sensor key with calibration and rapid trigger.
// Holds default parameters, field widths, register indexes and the
// command/status structs shared by the controller and the datapath.
package hkrt_pkg;

  localparam int unsigned ADC_BITS_DEF      = 10;
  localparam int unsigned TRAVEL_LEVELS_DEF = 40;
  localparam int unsigned HIST_DEPTH        = 3;

  localparam int unsigned LVL_W      = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RT_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACT_LEVEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REL_LEVELS = 2'd2;

  localparam logic [LVL_W-1:0] ACT_LEVEL_RST  = 6'd20;
  localparam logic [LVL_W-1:0] REL_LEVELS_RST = 6'd10;

  // Commands from the controller to the datapath, one step each.
  typedef struct packed {
    logic load;   // take the input item, shift the sample history
    logic mul;    // sum the history and multiply by the reciprocal of three
    logic corr;   // correct the quotient estimate into the average
    logic prep;   // form the scaled numerator and start the divider
    logic step;   // one restoring division step
    logic fin;    // update key state and load the result
  } hkrt_cmd_t;

  typedef struct packed {
    logic div_last;
  } hkrt_status_t;

endpackage

[sv/hkrt_in_if.sv]
// Input channel of the Hall-sensor key: one raw sample and a calibration flag.
// Depends on hkrt_pkg for the default sample width.
interface hkrt_in_if import hkrt_pkg::*; #(
  parameter int unsigned ADC_BITS = ADC_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;
  logic                calib_press;

  modport source (output valid, output adc_sample, output calib_press, input ready);
  modport sink (input valid, input adc_sample, input calib_press, output ready);
endinterface

[sv/hkrt_out_if.sv]
// Result channel of the Hall-sensor key: actuation, level and calibration state.
// Depends on hkrt_pkg for the default sample width and the level width.
interface hkrt_out_if import hkrt_pkg::*; #(
  parameter int unsigned ADC_BITS = ADC_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic                actuated;
  logic [LVL_W-1:0]    key_level;
  logic                calibrating;
  logic [ADC_BITS-1:0] cal_min;
  logic [ADC_BITS-1:0] cal_max;

  modport source (output valid, output actuated, output key_level, output calibrating,
                  output cal_min, output cal_max, input ready);
  modport sink (input valid, input actuated, input key_level, input calibrating,
                input cal_min, input cal_max, output ready);
endinterface

[sv/hkrt_ctrl.sv]
// Controller of the Hall-sensor key: sequences the averaging, the divider
// and the state update, and owns both handshakes. Depends on hkrt_pkg.
module hkrt_ctrl import hkrt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  hkrt_status_t status_i,
  output hkrt_cmd_t    cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StCorr = 3'd2;
  localparam logic [2:0] StPrep = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       fin;

  // The result register frees up in the same cycle its transfer completes.
  assign fin = (state_q == StFin) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StMul;
      StMul:  state_d = StCorr;
      StCorr: state_d = StPrep;
      StPrep: state_d = StDiv;
      StDiv:  if (status_i.div_last) state_d = StFin;
      StFin:  if (fin) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    if (fin) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  assign cmd_o.load = (state_q == StIdle) && in_valid_i;
  assign cmd_o.mul  = (state_q == StMul);
  assign cmd_o.corr = (state_q == StCorr);
  assign cmd_o.prep = (state_q == StPrep);
  assign cmd_o.step = (state_q == StDiv);
  assign cmd_o.fin  = fin;

endmodule

[sv/hkrt_dp.sv]
// Datapath of the Hall-sensor key: sample history, average by reciprocal
// multiply, restoring divider, calibration and actuation state, and the
// configuration registers. Depends on hkrt_pkg.
module hkrt_dp import hkrt_pkg::*; #(
  parameter int unsigned ADC_BITS      = ADC_BITS_DEF,
  parameter int unsigned TRAVEL_LEVELS = TRAVEL_LEVELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  hkrt_cmd_t             cmd_i,
  output hkrt_status_t          status_o,
  input  logic [ADC_BITS-1:0]   sample_i,
  input  logic                  press_i,
  output logic                  actuated_o,
  output logic [LVL_W-1:0]      key_level_o,
  output logic                  calibrating_o,
  output logic [ADC_BITS-1:0]   cal_min_o,
  output logic [ADC_BITS-1:0]   cal_max_o
);

  localparam int unsigned SUM_W  = ADC_BITS + 2;
  localparam int unsigned RCP_SH = SUM_W + 1;
  localparam int unsigned PROD_W = SUM_W + RCP_SH;
  localparam int unsigned NUM_W  = ADC_BITS + LVL_W;
  localparam int unsigned CNT_W  = $clog2(NUM_W);
  localparam logic [RCP_SH-1:0]   RCP     = RCP_SH'((64'd1 << RCP_SH) / 3);
  localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};
  localparam logic [LVL_W-1:0]    LEVELS  = LVL_W'(TRAVEL_LEVELS);
  localparam logic [NUM_W-1:0]    LEVELS_N = NUM_W'(TRAVEL_LEVELS);

  // Configuration registers.
  logic             rt_en_q;
  logic [LVL_W-1:0] act_lvl_q;
  logic [LVL_W-1:0] rel_lvl_q;

  // Key state.
  logic [ADC_BITS-1:0] hist_q [HIST_DEPTH];
  logic [ADC_BITS-1:0] min_q, max_q, range_q;
  logic                calib_q;
  logic [LVL_W-1:0]    peak_q;
  logic                act_q;

  // Per-item working registers.
  logic                press_q;
  logic [SUM_W-1:0]    sum_q;
  logic [PROD_W-1:0]   prod_q;
  logic [ADC_BITS-1:0] avg_q;
  logic                below_q;
  logic [ADC_BITS-1:0] rem_q;
  logic [NUM_W-1:0]    quo_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [LVL_W-1:0]    level_q;

  logic [SUM_W-1:0]    sum;
  logic [ADC_BITS-1:0] q0;
  logic [SUM_W-1:0]    rem3;
  logic [ADC_BITS-1:0] avg;
  logic [NUM_W-1:0]    num;
  logic [ADC_BITS:0]   trial;
  logic                ge;
  logic [ADC_BITS:0]   trial_sub;
  logic [LVL_W-1:0]    level;
  logic [ADC_BITS-1:0] sample;

  logic                calib_n;
  logic [ADC_BITS-1:0] min_n, max_n, range_n;
  logic [LVL_W-1:0]    peak_n;
  logic                act_n;

  assign sum = SUM_W'(hist_q[0]) + SUM_W'(hist_q[1]) + SUM_W'(hist_q[2]);

  // The reciprocal estimate is at most one below the true quotient, so a
  // remainder of three or more means one more.
  assign q0   = prod_q[RCP_SH +: ADC_BITS];
  assign rem3 = sum_q - SUM_W'({q0, 1'b0}) - SUM_W'(q0);
  assign avg  = (rem3 >= SUM_W'(3)) ? q0 + ADC_BITS'(1) : q0;

  assign num = NUM_W'(avg_q - min_q) * LEVELS_N;

  // A zero range makes every step subtract, so the quotient saturates and
  // clamps to the top level, as it should when the average is not below min.
  assign trial     = {rem_q, quo_q[NUM_W-1]};
  assign ge        = trial >= {1'b0, range_q};
  assign trial_sub = trial - {1'b0, range_q};

  always_comb begin
    if (below_q) begin
      level = '0;
    end else if (quo_q > LEVELS_N) begin
      level = LEVELS;
    end else begin
      level = quo_q[LVL_W-1:0];
    end
  end

  assign status_o.div_last = (cnt_q == CNT_W'(NUM_W - 1));

  assign sample = hist_q[HIST_DEPTH-1];

  always_comb begin
    calib_n = calib_q;
    min_n   = min_q;
    max_n   = max_q;
    range_n = range_q;
    peak_n  = peak_q;
    act_n   = act_q;
    if (press_q) begin
      if (!calib_q) begin
        calib_n = 1'b1;
        max_n   = '0;
        min_n   = sample;
      end else begin
        calib_n = 1'b0;
        range_n = (max_q >= min_q) ? max_q - min_q : '0;
      end
    end
    if (!calib_n) begin
      if (rt_en_q) begin
        if ((level == '0) ||
            ({1'b0, level} + {1'b0, rel_lvl_q} < {1'b0, peak_n})) begin
          peak_n = level;
          act_n  = 1'b0;
        end
        if (level > peak_n) begin
          peak_n = level;
          act_n  = 1'b1;
        end
      end else begin
        act_n = (level >= act_lvl_q);
      end
    end else begin
      if (sample > max_n) max_n = sample;
      if (sample < min_n) min_n = sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_en_q   <= 1'b0;
      act_lvl_q <= ACT_LEVEL_RST;
      rel_lvl_q <= REL_LEVELS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RT_ENABLE:  rt_en_q   <= cfg_data_i[0];
        REG_ACT_LEVEL:  act_lvl_q <= cfg_data_i[LVL_W-1:0];
        REG_REL_LEVELS: rel_lvl_q <= cfg_data_i[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
      min_q   <= '0;
      max_q   <= '0;
      range_q <= ADC_MAX;
      calib_q <= 1'b0;
      peak_q  <= '0;
      act_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        for (int i = 0; i < HIST_DEPTH - 1; i++) begin
          hist_q[i] <= hist_q[i+1];
        end
        hist_q[HIST_DEPTH-1] <= sample_i;
      end
      if (cmd_i.fin) begin
        min_q   <= min_n;
        max_q   <= max_n;
        range_q <= range_n;
        calib_q <= calib_n;
        peak_q  <= peak_n;
        act_q   <= act_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      press_q <= press_i;
    end
    if (cmd_i.mul) begin
      sum_q  <= sum;
      prod_q <= PROD_W'(sum) * PROD_W'(RCP);
    end
    if (cmd_i.corr) begin
      avg_q <= avg;
    end
    if (cmd_i.prep) begin
      below_q <= (avg_q < min_q);
      rem_q   <= '0;
      quo_q   <= num;
      cnt_q   <= '0;
    end
    if (cmd_i.step) begin
      rem_q <= ge ? trial_sub[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.fin) begin
      level_q <= level;
    end
  end

  assign actuated_o    = act_q;
  assign key_level_o   = level_q;
  assign calibrating_o = calib_q;
  assign cal_min_o     = min_q;
  assign cal_max_o     = max_q;

endmodule

[sv/hall_key_rapid_trigger.sv]
// Hall-sensor analog key with calibration and rapid trigger, top level.
// Depends on hkrt_pkg, hkrt_in_if, hkrt_out_if, hkrt_ctrl and hkrt_dp.
//
// Usage:
//   The input channel carries one raw ADC sample and a calibration-press flag
//   per transfer. Each input transfer produces exactly one result transfer on
//   the output channel: actuation state, travel level of the three-sample
//   average, calibration mode and the calibration minimum and maximum.
//   Configuration (rapid trigger enable, actuation level, release distance)
//   is written through cfg_we_i / cfg_idx_i / cfg_data_i while no item is in
//   flight; index 3 is ignored.
// Sequence:
//   One item is worked at a time. After an input transfer the block does
//   the reciprocal multiply, the correction, the numerator, the steps of the
//   bit-serial divider and the state update, in that order, and takes a new
//   item only once the previous result is loaded into the output register.
// Reset and stall:
//   Reset clears history, calibration (range to full scale) and actuation.
//   A result waits in its output register while the receiver stalls; the
//   next item is still accepted and is held at its final step until the
//   register frees up.
module hall_key_rapid_trigger import hkrt_pkg::*; #(
  parameter int unsigned ADC_BITS      = ADC_BITS_DEF,
  parameter int unsigned TRAVEL_LEVELS = TRAVEL_LEVELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  hkrt_in_if.sink               in_if,
  hkrt_out_if.source            out_if
);

  hkrt_cmd_t    cmd;
  hkrt_status_t status;

  hkrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hkrt_dp #(
    .ADC_BITS     (ADC_BITS),
    .TRAVEL_LEVELS(TRAVEL_LEVELS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_i     (in_if.adc_sample),
    .press_i      (in_if.calib_press),
    .actuated_o   (out_if.actuated),
    .key_level_o  (out_if.key_level),
    .calibrating_o(out_if.calibrating),
    .cal_min_o    (out_if.cal_min),
    .cal_max_o    (out_if.cal_max)
  );

endmodule

[sv/hkrt_checker.sv]
// Port-level checks for the Hall-sensor key, bound to the top level.
// Depends on hkrt_pkg, hkrt_in_if, hkrt_out_if and hall_key_rapid_trigger.
module hkrt_checker import hkrt_pkg::*; #(
  parameter int unsigned ADC_BITS      = ADC_BITS_DEF,
  parameter int unsigned TRAVEL_LEVELS = TRAVEL_LEVELS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  hkrt_in_if.sink    in_if,
  hkrt_out_if.source out_if
);

  localparam logic [LVL_W-1:0] LEVELS = LVL_W'(TRAVEL_LEVELS);

  // A stalled result keeps its value until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.key_level)
      && $stable(out_if.actuated) && $stable(out_if.cal_min) && $stable(out_if.cal_max))
    else $error("result changed while stalled");

  // Only one item is worked at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("input taken while an item is in flight");

  // The result never follows the input transfer in the very next cycle.
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready && !out_if.valid |=> !out_if.valid)
    else $error("result appeared too early");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.key_level <= LEVELS)
    else $error("key level above travel range");

  // Tracking during calibration keeps the minimum at or below the maximum.
  a_cal_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.calibrating |-> out_if.cal_min <= out_if.cal_max)
    else $error("calibration minimum above maximum");

endmodule

bind hall_key_rapid_trigger hkrt_checker #(
  .ADC_BITS     (ADC_BITS),
  .TRAVEL_LEVELS(TRAVEL_LEVELS)
) u_hkrt_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .in_if (in_if),
  .out_if(out_if)
);

[tb/hall_key_rapid_trigger_test.sv]
// Self-checking testbench for the Hall-sensor key with calibration and rapid trigger.
// Drives samples through hkrt_in_if and checks every transfer on hkrt_out_if
// against an in-bench key model. Depends on hkrt_pkg, both interfaces and the DUT.
module hall_key_rapid_trigger_test;
  import hkrt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ADC_W        = ADC_BITS_DEF;
  localparam int unsigned LEVELS       = TRAVEL_LEVELS_DEF;
  localparam int          ADC_TOP      = (1 << ADC_W) - 1;
  localparam int unsigned ITEMS_PER_PH = 100;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned NUM_DIRECTED = 22;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 10;

  // The register list ends at index 2; writes to this index must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic                actuated;
    logic [LVL_W-1:0]    key_level;
    logic                calibrating;
    logic [ADC_W-1:0]    cal_min;
    logic [ADC_W-1:0]    cal_max;
  } key_result_t;

  typedef struct {
    logic [ADC_W-1:0] sample;
    logic             press;
    bit               typed;
    key_result_t      want;
  } stim_row_t;

  typedef struct {
    logic             rt_on;
    logic [LVL_W-1:0] thresh;
    logic [LVL_W-1:0] release_dist;
  } key_setting_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_LONG,
    STALL_BEAT
  } stall_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  hkrt_in_if  in_ch ();
  hkrt_out_if out_ch ();

  hall_key_rapid_trigger u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // Model state of the key and its settings.
  logic [ADC_W-1:0] hist_q [3];
  logic [ADC_W-1:0] cal_lo;
  logic [ADC_W-1:0] cal_hi;
  logic [ADC_W-1:0] cal_span;
  logic             in_cal;
  logic [LVL_W-1:0] peak_lvl;
  logic             key_down;
  logic             rt_on;
  logic [LVL_W-1:0] thresh_lvl;
  logic [LVL_W-1:0] release_lvl;

  key_result_t pending_results [$];
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned burst_left;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{10'd0,    1'b0, 1'b1, '{1'b0, 6'd0,  1'b0, 10'd0,   10'd0}},
    '{10'd1023, 1'b0, 1'b1, '{1'b0, 6'd13, 1'b0, 10'd0,   10'd0}},
    '{10'd1023, 1'b0, 1'b0, '0},
    '{10'd1023, 1'b0, 1'b1, '{1'b1, 6'd40, 1'b0, 10'd0,   10'd0}},
    '{10'd512,  1'b1, 1'b1, '{1'b1, 6'd33, 1'b1, 10'd512, 10'd512}},
    '{10'd100,  1'b0, 1'b0, '0},
    '{10'd900,  1'b0, 1'b0, '0},
    '{10'd500,  1'b1, 1'b0, '0},
    '{10'd1023, 1'b0, 1'b0, '0},
    '{10'd1023, 1'b0, 1'b0, '0},
    '{10'd1023, 1'b0, 1'b1, '{1'b1, 6'd40, 1'b0, 10'd100, 10'd900}},
    '{10'd0,    1'b0, 1'b0, '0},
    '{10'd0,    1'b0, 1'b0, '0},
    '{10'd0,    1'b0, 1'b1, '{1'b0, 6'd0,  1'b0, 10'd100, 10'd900}},
    '{10'd300,  1'b1, 1'b0, '0},
    '{10'd300,  1'b1, 1'b0, '0},
    '{10'd300,  1'b0, 1'b1, '{1'b1, 6'd40, 1'b0, 10'd300, 10'd300}},
    '{10'd299,  1'b0, 1'b1, '{1'b0, 6'd0,  1'b0, 10'd300, 10'd300}},
    '{10'd1023, 1'b1, 1'b0, '0},
    '{10'd0,    1'b0, 1'b0, '0},
    '{10'd0,    1'b1, 1'b0, '0},
    '{10'd1023, 1'b0, 1'b0, '0}
  };

  key_setting_t phase_cfg [NUM_PHASES] = '{
    '{1'b1, 6'd20, 6'd10},
    '{1'b1, 6'd0,  6'd0},
    '{1'b1, 6'd63, 6'd63},
    '{1'b0, 6'd0,  6'd40},
    '{1'b0, 6'd40, 6'd0},
    '{1'b0, 6'd63, 6'd5},
    '{1'b1, 6'd40, 6'd40},
    '{1'b1, 6'd7,  6'd3}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic key_result_t advance_key(input logic [ADC_W-1:0] smp, input logic press);
    int unsigned avg;
    int unsigned lvl;
    key_result_t res;
    hist_q[0] = hist_q[1];
    hist_q[1] = hist_q[2];
    hist_q[2] = smp;
    avg = (32'(hist_q[0]) + 32'(hist_q[1]) + 32'(hist_q[2])) / 3;
    // The level uses the calibration as it stood before this step's press.
    if (avg < cal_lo) begin
      lvl = 0;
    end else if (cal_span == '0) begin
      lvl = LEVELS;
    end else begin
      lvl = (avg - cal_lo) * LEVELS / cal_span;
      if (lvl > LEVELS) lvl = LEVELS;
    end
    if (press) begin
      if (!in_cal) begin
        in_cal = 1'b1;
        cal_hi = '0;
        cal_lo = smp;
      end else begin
        in_cal   = 1'b0;
        cal_span = (cal_hi >= cal_lo) ? cal_hi - cal_lo : '0;
      end
    end
    if (!in_cal) begin
      if (rt_on) begin
        if (lvl == 0 || lvl + release_lvl < peak_lvl) begin
          peak_lvl = LVL_W'(lvl);
          key_down = 1'b0;
        end
        if (lvl > peak_lvl) begin
          peak_lvl = LVL_W'(lvl);
          key_down = 1'b1;
        end
      end else begin
        key_down = (lvl >= thresh_lvl);
      end
    end else begin
      if (smp > cal_hi) cal_hi = smp;
      if (smp < cal_lo) cal_lo = smp;
    end
    res.actuated    = key_down;
    res.key_level   = LVL_W'(lvl);
    res.calibrating = in_cal;
    res.cal_min     = cal_lo;
    res.cal_max     = cal_hi;
    return res;
  endfunction

  // Sender: bursts of transfers separated by random gaps. Valid stays high
  // across back-to-back transfers inside a burst.
  task automatic send_sample(input logic [ADC_W-1:0] smp, input logic press,
                             input bit use_typed = 1'b0, input key_result_t typed_res = '0);
    key_result_t pred;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.adc_sample  <= smp;
    in_ch.calib_press <= press;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pred = advance_key(smp, press);
    pending_results.push_back(use_typed ? typed_res : pred);
    burst_left--;
    items_sent++;
  endtask

  // Drops valid and waits until every result has come back.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_key_setting(input key_setting_t s);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_RT_ENABLE;
    cfg_data_i <= {5'($urandom_range(0, 31)), s.rt_on};
    @(posedge clk_i);
    rt_on      = s.rt_on;
    cfg_idx_i  <= REG_ACT_LEVEL;
    cfg_data_i <= s.thresh;
    @(posedge clk_i);
    thresh_lvl = s.thresh;
    cfg_idx_i  <= REG_REL_LEVELS;
    cfg_data_i <= s.release_dist;
    @(posedge clk_i);
    release_lvl = s.release_dist;
    cfg_idx_i  <= REG_UNUSED;
    cfg_data_i <= CFG_DATA_W'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Press, sweep between two readings, press again; one in eight is left open.
  task automatic send_calibration();
    int lo;
    int hi;
    if ($urandom_range(0, 3) == 0) begin
      lo = 0;
      hi = ADC_TOP;
    end else begin
      lo = $urandom_range(0, 400);
      hi = $urandom_range(lo + 50, ADC_TOP);
    end
    send_sample(ADC_W'($urandom_range(lo, hi)), 1'b1);
    send_sample(ADC_W'(lo), 1'b0);
    repeat ($urandom_range(2, 8)) send_sample(ADC_W'($urandom_range(lo, hi)), 1'b0);
    send_sample(ADC_W'(hi), 1'b0);
    if ($urandom_range(0, 7) != 0) send_sample(ADC_W'($urandom_range(lo, hi)), 1'b1);
  endtask

  // A key stroke: travel that rises and falls with reversals and some jitter,
  // sometimes past the calibrated span.
  task automatic send_stroke();
    int lo;
    int hi;
    int pos;
    int dir;
    int stepmax;
    int smp;
    lo = cal_lo;
    hi = cal_hi;
    if (in_cal || hi < lo + 16) begin
      lo = 0;
      hi = ADC_TOP;
    end
    pos     = lo + $urandom_range(0, 8) - 4;
    dir     = 1;
    stepmax = (hi - lo) / 4 + 1;
    repeat ($urandom_range(8, 24)) begin
      smp = (pos < 0) ? 0 : (pos > ADC_TOP) ? ADC_TOP : pos;
      send_sample(ADC_W'(smp), 1'b0);
      if ($urandom_range(0, 4) == 0) dir = -dir;
      pos = pos + dir * $urandom_range(1, stepmax) + $urandom_range(0, 6) - 3;
      if (pos > hi + 40) dir = -1;
      if (pos < lo - 40) dir = 1;
    end
  endtask

  task automatic run_random_phase(input int unsigned quota);
    int unsigned target;
    int unsigned pick;
    target = items_sent + quota;
    while (items_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        send_calibration();
      end else if (pick < 8) begin
        send_stroke();
      end else begin
        repeat ($urandom_range(1, 4))
          send_sample(ADC_W'($urandom_range(0, ADC_TOP)), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // Receiver: checks each result transfer and stalls on a pattern that
  // switches between modes whenever a mode timer runs out.
  stall_mode_e stall_mode;
  int unsigned mode_timer;
  int unsigned stall_left;
  int unsigned beat;

  always @(posedge clk_i) begin
    key_result_t got;
    key_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.actuated, out_ch.key_level, out_ch.calibrating,
              out_ch.cal_min, out_ch.cal_max};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: act=%0d lvl=%0d cal=%0d min=%0d max=%0d",
                   got.actuated, got.key_level, got.calibrating, got.cal_min, got.cal_max);
      end else begin
        want = pending_results.pop_front();
        if (got.actuated !== want.actuated || got.key_level !== want.key_level ||
            got.calibrating !== want.calibrating || got.cal_min !== want.cal_min ||
            got.cal_max !== want.cal_max) begin
          fail_count++;
          // Fields in order: actuated, level, calibrating, minimum, maximum.
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                     want.actuated, want.key_level, want.calibrating, want.cal_min,
                     want.cal_max, got.actuated, got.key_level, got.calibrating,
                     got.cal_min, got.cal_max);
        end
      end
    end
    beat++;
    if (mode_timer == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_timer = 256;
    end
    mode_timer--;
    if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        STALL_NONE: begin
          out_ch.ready <= 1'b1;
        end
        STALL_COIN: begin
          out_ch.ready <= 1'($urandom_range(0, 1));
        end
        STALL_LONG: begin
          if ($urandom_range(0, 19) == 0) begin
            stall_left = $urandom_range(5, 30);
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
          end
        end
        default: begin
          out_ch.ready <= (beat[1:0] != 2'd0);
        end
      endcase
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.adc_sample  = '0;
    in_ch.calib_press = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_RT_ENABLE;
    cfg_data_i        = '0;
    rst_ni            = 1'b0;
    fail_count        = 0;
    cycle_count       = 0;
    items_sent        = 0;
    burst_left        = 0;
    stall_mode        = STALL_NONE;
    mode_timer        = 0;
    stall_left        = 0;
    beat              = 0;
    hist_q            = '{default: '0};
    cal_lo            = '0;
    cal_hi            = '0;
    cal_span          = ADC_W'(ADC_TOP);
    in_cal            = 1'b0;
    peak_lvl          = '0;
    key_down          = 1'b0;
    rt_on             = 1'b0;
    thresh_lvl        = ACT_LEVEL_RST;
    release_lvl       = REL_LEVELS_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run on the reset settings.
    foreach (directed_rows[i])
      send_sample(directed_rows[i].sample, directed_rows[i].press,
                  directed_rows[i].typed, directed_rows[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_block();
      write_key_setting(phase_cfg[ph]);
      run_random_phase(ITEMS_PER_PH);
    end

    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[hall_key_rapid_trigger.f]
sv/hkrt_pkg.sv
sv/hkrt_in_if.sv
sv/hkrt_out_if.sv
sv/hkrt_ctrl.sv
sv/hkrt_dp.sv
sv/hall_key_rapid_trigger.sv
sv/hkrt_checker.sv
tb/hall_key_rapid_trigger_test.sv
